@@ sv/markup_tag_balance_scanner_macros.svh @@
// Assertion macros shared by the markup tag balance scanner RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef MARKUP_TAG_BALANCE_SCANNER_MACROS_SVH
`define MARKUP_TAG_BALANCE_SCANNER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define MTBS_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("mtbs check failed");

// Next-cycle implication, disabled while reset is asserted
`define MTBS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("mtbs check failed");

`endif

@@ sv/mtbs_pkg.sv @@
// Package for the markup tag balance scanner: character codes and the
// depth counter command struct. No dependencies.
package mtbs_pkg;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;

    // Commands to the open depth counter
    typedef struct packed {
        logic inc;
        logic dec;
        logic clr;
    } depth_cmd_t;

endpackage

@@ sv/markup_tag_balance_scanner.sv @@
// A result is presented in the cycle after the byte that causes it is transferred.
// Throughput: one byte per cycle; the only stall is a held result register (m_ready low).
// The scan state updates in a single pass of logic between the state and result registers.
// Reset: aresetn is synchronous and active low; it clears the scan state and drops m_valid.
// Depends on mtbs_pkg, mtbs_depth_counter and markup_tag_balance_scanner_macros.svh.
`include "markup_tag_balance_scanner_macros.svh"

module markup_tag_balance_scanner #(
    parameter int DEPTH_BITS  = 16,
    parameter int LENGTH_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_text_byte,
    input  logic        s_end_of_string,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_found,
    output logic [15:0] m_valid_length,
    output logic        m_length_overflow
);

    // Scan state
    logic                   in_quotes_reg,   in_quotes_next;
    logic [7:0]             prev_byte_reg,   prev_byte_next;
    logic                   armed_reg,       armed_next;
    logic                   pending_reg,     pending_next;
    logic [LENGTH_BITS-1:0] pos_reg,         pos_next;
    logic                   sat_reg,         sat_next;
    logic                   finished_reg,    finished_next;

    // Result register
    logic        m_valid_reg,   m_valid_next;
    logic        found_reg,     found_next;
    logic [15:0] length_reg,    length_next;
    logic        overflow_reg,  overflow_next;

    logic                         accept;
    logic                         is_nul;
    logic                         active;
    logic                         outside;
    logic                         lt_seen;
    logic                         gt_seen;
    logic                         slash_close;
    logic                         gt_close;
    logic                         pos_full;
    logic [LENGTH_BITS-1:0]       pos_step;
    logic [LENGTH_BITS+15:0]      pos_wide;
    logic                         hit;
    logic                         emit;
    logic                         clr;
    logic                         sat_step;
    mtbs_pkg::depth_cmd_t         depth_cmd;
    logic signed [DEPTH_BITS-1:0] depth_step;

    // Input side stalls only when a result waits and is not taken this cycle
    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    // Byte decode
    assign is_nul      = (s_text_byte == mtbs_pkg::CH_NUL);
    assign active      = !finished_reg && !is_nul;
    assign outside     = !in_quotes_reg && (s_text_byte != mtbs_pkg::CH_QUOTE);
    assign lt_seen     = outside && (s_text_byte == mtbs_pkg::CH_LT);
    assign gt_seen     = outside && (s_text_byte == mtbs_pkg::CH_GT);
    assign slash_close = outside && (s_text_byte == mtbs_pkg::CH_SLASH)
                         && (prev_byte_reg == mtbs_pkg::CH_LT);
    assign gt_close    = gt_seen && ((prev_byte_reg == mtbs_pkg::CH_SLASH) || pending_reg);

    // Saturating position
    assign pos_full = &pos_reg;
    assign pos_step = pos_full ? pos_reg : pos_reg + LENGTH_BITS'(1);
    assign sat_step = sat_reg || pos_full;
    assign pos_wide = {16'd0, pos_step};

    // Depth counter commands
    assign clr           = accept && (is_nul || s_end_of_string);
    assign depth_cmd.inc = accept && active && lt_seen;
    assign depth_cmd.dec = accept && active && (slash_close || gt_close);
    assign depth_cmd.clr = clr;

    mtbs_depth_counter #(
        .DEPTH_BITS(DEPTH_BITS)
    ) u_depth (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (depth_cmd),
        .depth_step (depth_step)
    );

    // Element end found and result emission
    assign hit  = active && gt_seen && armed_reg && (depth_step == '0);
    assign emit = !finished_reg && (is_nul || hit || s_end_of_string);

    // Next scan state
    always_comb begin
        in_quotes_next = in_quotes_reg;
        prev_byte_next = prev_byte_reg;
        armed_next     = armed_reg;
        pending_next   = pending_reg;
        pos_next       = pos_reg;
        sat_next       = sat_reg;
        finished_next  = finished_reg;
        if (accept) begin
            if (clr) begin
                in_quotes_next = 1'b0;
                prev_byte_next = '0;
                armed_next     = 1'b0;
                pending_next   = 1'b0;
                pos_next       = '0;
                sat_next       = 1'b0;
                finished_next  = 1'b0;
            end else if (active) begin
                in_quotes_next = in_quotes_reg ^ (s_text_byte == mtbs_pkg::CH_QUOTE);
                prev_byte_next = s_text_byte;
                armed_next     = armed_reg || lt_seen;
                if (gt_seen) begin
                    pending_next = 1'b0;
                end else if (slash_close) begin
                    pending_next = 1'b1;
                end
                pos_next      = pos_step;
                sat_next      = sat_step;
                finished_next = hit;
            end
        end
    end

    // Next result register
    always_comb begin
        m_valid_next  = m_valid_reg && !m_ready;
        found_next    = found_reg;
        length_next   = length_reg;
        overflow_next = overflow_reg;
        if (accept && emit) begin
            m_valid_next  = 1'b1;
            found_next    = hit;
            length_next   = hit ? pos_wide[15:0] : 16'd0;
            overflow_next = is_nul ? sat_reg : sat_step;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_quotes_reg <= 1'b0;
            prev_byte_reg <= '0;
            armed_reg     <= 1'b0;
            pending_reg   <= 1'b0;
            pos_reg       <= '0;
            sat_reg       <= 1'b0;
            finished_reg  <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            in_quotes_reg <= in_quotes_next;
            prev_byte_reg <= prev_byte_next;
            armed_reg     <= armed_next;
            pending_reg   <= pending_next;
            pos_reg       <= pos_next;
            sat_reg       <= sat_next;
            finished_reg  <= finished_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge aclk) begin
        found_reg    <= found_next;
        length_reg   <= length_next;
        overflow_reg <= overflow_next;
    end

    assign m_valid           = m_valid_reg;
    assign m_found           = found_reg;
    assign m_valid_length    = length_reg;
    assign m_length_overflow = overflow_reg;

    // A miss always reports length zero
    `MTBS_ASSERT_NOW(a_miss_zero_len, aclk, aresetn,
        m_valid_reg && !found_reg, length_reg == 16'd0)
    // Bytes after a found element and before the string end give no result
    `MTBS_ASSERT_NEXT(a_finished_silent, aclk, aresetn,
        accept && finished_reg && !is_nul && !s_end_of_string, !m_valid_reg)
    // The saturation flag is only set once the position counter is full
    `MTBS_ASSERT_NOW(a_sat_pos_full, aclk, aresetn, sat_reg, pos_full)
    // Finished state is only ever entered with an element already reported
    `MTBS_ASSERT_NEXT(a_finish_reports, aclk, aresetn,
        !finished_reg && finished_next, m_valid_reg && found_reg)

endmodule

@@ sv/mtbs_depth_counter.sv @@
// Saturating signed up/down counter for the open tag depth.
// Depends on mtbs_pkg and markup_tag_balance_scanner_macros.svh.
`include "markup_tag_balance_scanner_macros.svh"

module mtbs_depth_counter #(
    parameter int DEPTH_BITS = 16
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  mtbs_pkg::depth_cmd_t         cmd,
    output logic signed [DEPTH_BITS-1:0] depth_step
);

    localparam logic signed [DEPTH_BITS-1:0] DEPTH_MAX = {1'b0, {(DEPTH_BITS-1){1'b1}}};
    localparam logic signed [DEPTH_BITS-1:0] DEPTH_MIN = {1'b1, {(DEPTH_BITS-1){1'b0}}};

    logic signed [DEPTH_BITS-1:0] depth_reg;
    logic signed [DEPTH_BITS-1:0] depth_next;

    // Stepped value before any clear; the top level uses it for the hit test
    always_comb begin
        depth_step = depth_reg;
        if (cmd.inc && depth_reg != DEPTH_MAX) begin
            depth_step = depth_reg + DEPTH_BITS'(1);
        end else if (cmd.dec && depth_reg != DEPTH_MIN) begin
            depth_step = depth_reg - DEPTH_BITS'(1);
        end
        depth_next = cmd.clr ? '0 : depth_step;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            depth_reg <= '0;
        end else begin
            depth_reg <= depth_next;
        end
    end

    // Saturation: no wrap at either end of the signed range
    `MTBS_ASSERT_NEXT(a_depth_hold_max, aclk, aresetn,
        cmd.inc && !cmd.clr && depth_reg == DEPTH_MAX, depth_reg == DEPTH_MAX)
    `MTBS_ASSERT_NEXT(a_depth_hold_min, aclk, aresetn,
        cmd.dec && !cmd.inc && !cmd.clr && depth_reg == DEPTH_MIN, depth_reg == DEPTH_MIN)
    `MTBS_ASSERT_NEXT(a_depth_clear, aclk, aresetn, cmd.clr, depth_reg == '0)

endmodule

@@ verif/markup_tag_balance_scanner_tb.sv @@
// Self-checking testbench for markup_tag_balance_scanner: drives text bytes, predicts
// the balanced element end of each string and checks every result transfer.
// Depends on mtbs_pkg and the scanner RTL only.
module markup_tag_balance_scanner_tb;

    // One result transfer
    typedef struct packed {
        logic        found;
        logic [15:0] length;
        logic        overflow;
    } scan_result_t;

    // How a directed row is checked
    typedef enum logic [1:0] {
        USE_MODEL,
        NO_RESULT,
        GIVES_RESULT
    } row_check_t;

    // How a generated string is ended
    typedef enum logic [1:0] {
        END_LAST,
        END_NUL,
        END_OPEN
    } string_end_t;

    typedef struct packed {
        logic [7:0]   ch;
        logic         last;
        row_check_t   chk;
        scan_result_t res;
    } plan_row_t;

    localparam int                 NUM_ROWS    = 27;
    localparam logic signed [15:0] DEPTH_TOP    = 16'sh7FFF;
    localparam logic signed [15:0] DEPTH_BOTTOM = 16'sh8000;
    localparam scan_result_t       R_EMPTY     = '{1'b0, 16'd0, 1'b0};

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_text_byte = 8'h00;
    logic        s_end_of_string = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_found;
    logic [15:0] m_valid_length;
    logic        m_length_overflow;

    markup_tag_balance_scanner dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_text_byte       (s_text_byte),
        .s_end_of_string   (s_end_of_string),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_found           (m_found),
        .m_valid_length    (m_valid_length),
        .m_length_overflow (m_length_overflow)
    );

    always #4 aclk = ~aclk;

    // Predicted scan state
    logic               in_quote;
    logic [7:0]         prev_ch;
    logic               armed;
    logic               close_pend;
    logic signed [15:0] open_depth;
    logic [15:0]        byte_pos;
    logic               pos_sat;
    logic               scan_done;

    scan_result_t pending_results [$];
    logic [7:0]   text_q [$];
    plan_row_t    plan [NUM_ROWS];

    row_check_t   cur_check = USE_MODEL;
    scan_result_t cur_typed = '0;
    int           src_idle = 0;
    int           snk_idle = 0;
    int           bytes_seen = 0;
    int           live_bytes = 0;
    int           results_seen = 0;
    int           err_cnt = 0;

    scan_result_t want_r;
    scan_result_t pred_r;
    logic         pred_gives;

    function automatic void clear_scan();
        in_quote   = 1'b0;
        prev_ch    = mtbs_pkg::CH_NUL;
        armed      = 1'b0;
        close_pend = 1'b0;
        open_depth = '0;
        byte_pos   = '0;
        pos_sat    = 1'b0;
        scan_done  = 1'b0;
    endfunction

    // Advance the predicted state by one byte; gives is set when a result follows
    function automatic void scan_byte(input logic [7:0] ch, input logic last,
                                      output logic gives, output scan_result_t r);
        logic hit;
        gives = 1'b0;
        r     = R_EMPTY;
        hit   = 1'b0;
        // rest of a string after its result is skipped
        if (scan_done) begin
            if (last || ch == mtbs_pkg::CH_NUL)
                clear_scan();
            return;
        end
        // terminator: not counted, reports not found
        if (ch == mtbs_pkg::CH_NUL) begin
            gives      = 1'b1;
            r.overflow = pos_sat;
            clear_scan();
            return;
        end
        if (byte_pos == 16'hFFFF)
            pos_sat = 1'b1;
        else
            byte_pos = byte_pos + 16'd1;
        if (ch == mtbs_pkg::CH_QUOTE) begin
            in_quote = ~in_quote;
        end else if (!in_quote) begin
            if (ch == mtbs_pkg::CH_LT) begin
                if (open_depth != DEPTH_TOP)
                    open_depth = open_depth + 16'sd1;
                armed = 1'b1;
            end else if (ch == mtbs_pkg::CH_SLASH) begin
                if (prev_ch == mtbs_pkg::CH_LT) begin
                    close_pend = 1'b1;
                    if (open_depth != DEPTH_BOTTOM)
                        open_depth = open_depth - 16'sd1;
                end
            end else if (ch == mtbs_pkg::CH_GT) begin
                if ((prev_ch == mtbs_pkg::CH_SLASH || close_pend)
                    && open_depth != DEPTH_BOTTOM)
                    open_depth = open_depth - 16'sd1;
                close_pend = 1'b0;
                hit = (open_depth == 16'sd0) && armed;
            end
        end
        prev_ch = ch;
        if (hit) begin
            gives      = 1'b1;
            r.found    = 1'b1;
            r.length   = byte_pos;
            r.overflow = pos_sat;
            if (last)
                clear_scan();
            else
                scan_done = 1'b1;
        end else if (last) begin
            gives      = 1'b1;
            r.overflow = pos_sat;
            clear_scan();
        end
    endfunction

    // Result checking and prediction at each rising edge
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                results_seen++;
                if (pending_results.size() == 0) begin
                    err_cnt++;
                    $display("%0t: unexpected result found=%0d length=%0d overflow=%0d",
                             $time, m_found, m_valid_length, m_length_overflow);
                end else begin
                    want_r = pending_results.pop_front();
                    if (m_found !== want_r.found) begin
                        err_cnt++;
                        $display("%0t: found mismatch: expected %0d, actual %0d",
                                 $time, want_r.found, m_found);
                    end
                    if (m_valid_length !== want_r.length) begin
                        err_cnt++;
                        $display("%0t: valid_length mismatch: expected %0d, actual %0d",
                                 $time, want_r.length, m_valid_length);
                    end
                    if (m_length_overflow !== want_r.overflow) begin
                        err_cnt++;
                        $display("%0t: length_overflow mismatch: expected %0d, actual %0d",
                                 $time, want_r.overflow, m_length_overflow);
                    end
                end
            end
            if (s_valid && s_ready) begin
                bytes_seen++;
                if (!scan_done)
                    live_bytes++;
                scan_byte(s_text_byte, s_end_of_string, pred_gives, pred_r);
                case (cur_check)
                    NO_RESULT: ;
                    GIVES_RESULT: pending_results.push_back(cur_typed);
                    default: begin
                        if (pred_gives)
                            pending_results.push_back(pred_r);
                    end
                endcase
            end
        end
    end

    // Result side back-pressure
    always @(negedge aclk) begin
        if (!aresetn)
            m_ready <= 1'b0;
        else
            m_ready <= ($urandom_range(0, 99) >= snk_idle);
    end

    // Send one byte; returns at the falling edge after its transfer
    task automatic push_byte(input logic [7:0] ch, input logic last,
                             input row_check_t chk, input scan_result_t typed);
        while ($urandom_range(0, 99) < src_idle) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        cur_check = chk;
        cur_typed = typed;
        s_valid         <= 1'b1;
        s_text_byte     <= ch;
        s_end_of_string <= last;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    function automatic logic [7:0] letter();
        return 8'($urandom_range(97, 122));
    endfunction

    function automatic logic [7:0] special_char();
        case ($urandom_range(0, 3))
            0: return mtbs_pkg::CH_LT;
            1: return mtbs_pkg::CH_GT;
            2: return mtbs_pkg::CH_SLASH;
            default: return mtbs_pkg::CH_QUOTE;
        endcase
    endfunction

    // Anything, zero included, weighted toward the tag characters
    function automatic logic [7:0] noise_byte();
        case ($urandom_range(0, 3))
            0: return special_char();
            1: return letter();
            2: return 8'($urandom_range(0, 255));
            default: return 8'($urandom_range(1, 255));
        endcase
    endfunction

    // Append one element with random name, attribute and children
    function automatic void gen_elem(input int lvl);
        logic [7:0] nm [4];
        logic [7:0] c;
        int         nlen;
        int         kids;
        nlen = $urandom_range(1, 4);
        for (int i = 0; i < nlen; i++)
            nm[i] = letter();
        text_q.push_back(mtbs_pkg::CH_LT);
        for (int i = 0; i < nlen; i++)
            text_q.push_back(nm[i]);
        // quoted attribute value may hold any tag character
        if ($urandom_range(0, 2) == 0) begin
            text_q.push_back(8'h20);
            text_q.push_back(letter());
            text_q.push_back(8'h3D);
            text_q.push_back(mtbs_pkg::CH_QUOTE);
            for (int i = $urandom_range(0, 5); i > 0; i--) begin
                c = 8'($urandom_range(1, 255));
                text_q.push_back(c == mtbs_pkg::CH_QUOTE ? mtbs_pkg::CH_LT : c);
            end
            text_q.push_back(mtbs_pkg::CH_QUOTE);
        end
        if (lvl >= 3 || $urandom_range(0, 2) == 0) begin
            text_q.push_back(mtbs_pkg::CH_SLASH);
            text_q.push_back(mtbs_pkg::CH_GT);
        end else begin
            text_q.push_back(mtbs_pkg::CH_GT);
            kids = $urandom_range(0, 2);
            for (int k = 0; k < kids; k++) begin
                if ($urandom_range(0, 1) == 0)
                    gen_elem(lvl + 1);
                else
                    for (int i = $urandom_range(1, 3); i > 0; i--)
                        text_q.push_back(letter());
            end
            text_q.push_back(mtbs_pkg::CH_LT);
            text_q.push_back(mtbs_pkg::CH_SLASH);
            for (int i = 0; i < nlen; i++)
                text_q.push_back(nm[i]);
            text_q.push_back(mtbs_pkg::CH_GT);
        end
    endfunction

    // Build one string: mostly well-formed markup, some noise and damage
    function automatic void build_text();
        int shape;
        int cut;
        text_q.delete();
        shape = $urandom_range(0, 9);
        if (shape <= 5) begin
            for (int i = $urandom_range(0, 2); i > 0; i--)
                text_q.push_back(letter());
            gen_elem(0);
            for (int i = $urandom_range(0, 4); i > 0; i--)
                text_q.push_back(8'($urandom_range(1, 255)));
        end else if (shape == 6) begin
            for (int i = $urandom_range(1, 16); i > 0; i--)
                text_q.push_back(noise_byte());
        end else if (shape == 7) begin
            // truncated element
            gen_elem(0);
            cut = $urandom_range(1, text_q.size() - 1);
            while (text_q.size() > cut)
                void'(text_q.pop_back());
        end else if (shape == 8) begin
            // one byte of an element damaged
            gen_elem(0);
            text_q[$urandom_range(0, text_q.size() - 1)] = noise_byte();
        end else begin
            // stray closing tag ahead of an element
            text_q.push_back(mtbs_pkg::CH_LT);
            text_q.push_back(mtbs_pkg::CH_SLASH);
            text_q.push_back(letter());
            text_q.push_back(mtbs_pkg::CH_GT);
            gen_elem(0);
        end
    endfunction

    task automatic send_text();
        string_end_t how;
        int          r;
        r   = $urandom_range(0, 9);
        how = (r < 6) ? END_LAST : (r < 9) ? END_NUL : END_OPEN;
        if (how == END_NUL)
            text_q.push_back(mtbs_pkg::CH_NUL);
        for (int i = 0; i < text_q.size(); i++) begin
            if (i == text_q.size() - 1 && how == END_LAST)
                push_byte(text_q[i], 1'b1, USE_MODEL, R_EMPTY);
            else if (i == text_q.size() - 1 && how == END_NUL)
                push_byte(text_q[i], 1'($urandom_range(0, 1)), USE_MODEL, R_EMPTY);
            else
                push_byte(text_q[i], 1'b0, USE_MODEL, R_EMPTY);
        end
    endtask

    task automatic run_random(input int upto);
        while (bytes_seen < upto) begin
            build_text();
            send_text();
        end
    endtask

    // Stimulus
    initial begin
        clear_scan();
        plan = '{
            // zero byte right after reset, then with the last flag as well
            '{mtbs_pkg::CH_NUL,   1'b0, GIVES_RESULT, R_EMPTY},
            '{mtbs_pkg::CH_NUL,   1'b1, GIVES_RESULT, R_EMPTY},
            // self-closing element, closing '>' at position 4
            '{mtbs_pkg::CH_LT,    1'b0, NO_RESULT,    R_EMPTY},
            '{8'h61,              1'b0, NO_RESULT,    R_EMPTY},
            '{mtbs_pkg::CH_SLASH, 1'b0, NO_RESULT,    R_EMPTY},
            '{mtbs_pkg::CH_GT,    1'b0, GIVES_RESULT, '{1'b1, 16'd4, 1'b0}},
            // bytes after a result are skipped until the string ends
            '{8'hFF,              1'b0, NO_RESULT,    R_EMPTY},
            '{mtbs_pkg::CH_LT,    1'b1, NO_RESULT,    R_EMPTY},
            // lone byte carrying the last flag
            '{8'h80,              1'b1, GIVES_RESULT, R_EMPTY},
            // quoted '<' is not a tag
            '{mtbs_pkg::CH_QUOTE, 1'b0, USE_MODEL,    R_EMPTY},
            '{mtbs_pkg::CH_LT,    1'b0, USE_MODEL,    R_EMPTY},
            '{mtbs_pkg::CH_QUOTE, 1'b0, USE_MODEL,    R_EMPTY},
            '{mtbs_pkg::CH_LT,    1'b0, USE_MODEL,    R_EMPTY},
            '{8'h62,              1'b0, USE_MODEL,    R_EMPTY},
            '{mtbs_pkg::CH_SLASH, 1'b0, USE_MODEL,    R_EMPTY},
            '{mtbs_pkg::CH_GT,    1'b0, USE_MODEL,    R_EMPTY},
            // terminator after a result only clears the state
            '{mtbs_pkg::CH_NUL,   1'b0, USE_MODEL,    R_EMPTY},
            // open and close tag pair, found on the last byte
            '{mtbs_pkg::CH_LT,    1'b0, USE_MODEL,    R_EMPTY},
            '{8'h78,              1'b0, USE_MODEL,    R_EMPTY},
            '{mtbs_pkg::CH_GT,    1'b0, USE_MODEL,    R_EMPTY},
            '{mtbs_pkg::CH_LT,    1'b0, USE_MODEL,    R_EMPTY},
            '{mtbs_pkg::CH_SLASH, 1'b0, USE_MODEL,    R_EMPTY},
            '{8'h78,              1'b0, USE_MODEL,    R_EMPTY},
            '{mtbs_pkg::CH_GT,    1'b1, USE_MODEL,    R_EMPTY},
            // unfinished closing tag cut by a terminator
            '{mtbs_pkg::CH_LT,    1'b0, USE_MODEL,    R_EMPTY},
            '{mtbs_pkg::CH_SLASH, 1'b0, USE_MODEL,    R_EMPTY},
            '{mtbs_pkg::CH_NUL,   1'b1, GIVES_RESULT, R_EMPTY}
        };

        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // slow sender, heavy back-pressure
        src_idle = 36;
        snk_idle = 84;
        for (int i = 0; i < NUM_ROWS; i++)
            push_byte(plan[i].ch, plan[i].last, plan[i].chk, plan[i].res);
        run_random(360);

        // roles swapped
        src_idle = 84;
        snk_idle = 36;
        run_random(710);

        // full rate
        src_idle = 0;
        snk_idle = 0;
        run_random(1040);
        s_valid <= 1'b0;

        // drain
        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);

        $display("Scanned %0d bytes (%0d inside active scans), checked %0d results", bytes_seen,
                 live_bytes, results_seen);
        $display("Covered quoting, nested, self-closing and broken tags, terminators, stalls");
        if (err_cnt == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Watchdog
    initial begin
        #24000000;
        $display("%0t: timeout, %0d results still outstanding", $time,
                 pending_results.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+sv
sv/mtbs_pkg.sv
sv/mtbs_depth_counter.sv
sv/markup_tag_balance_scanner.sv
verif/markup_tag_balance_scanner_tb.sv
